/* rtl/utf8d_pkg.sv */
package utf8d_pkg;

  localparam int unsigned CpWidth = 31;
  localparam int unsigned ExpWidth = 3;

  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Tag = 8'hF0;
  localparam logic [7:0] Lead5Mask = 8'hFC;
  localparam logic [7:0] Lead5Tag = 8'hF8;
  localparam logic [7:0] Lead6Mask = 8'hFE;
  localparam logic [7:0] Lead6Tag = 8'hFC;

  localparam logic [ExpWidth-1:0] MaxExpected = 3'd5;

  typedef struct packed {
    logic [ExpWidth-1:0] expected;
    logic [CpWidth-1:0]  partial;
    logic                ended;
  } dec_state_t;

  typedef struct packed {
    logic               emit;
    logic [CpWidth-1:0] code_point;
    logic               has_code_point;
    logic               done_res;
  } dec_result_t;

endpackage

/* rtl/utf8d_decode.sv */
module utf8d_decode (
  input  utf8d_pkg::dec_state_t  state,
  input  logic [7:0]             data_byte,
  input  logic                   buffer_end,
  output utf8d_pkg::dec_state_t  state_next,
  output utf8d_pkg::dec_result_t result
);

  logic                             is_cont;
  logic                             have;
  logic [utf8d_pkg::CpWidth-1:0]    cp;
  logic [utf8d_pkg::CpWidth-1:0]    shifted;
  logic [utf8d_pkg::ExpWidth-1:0]   exp_dec;
  utf8d_pkg::dec_state_t            work;

  assign is_cont = (data_byte & utf8d_pkg::ContMask) == utf8d_pkg::ContTag;
  assign shifted = {state.partial[utf8d_pkg::CpWidth-7:0], data_byte[5:0]};
  assign exp_dec = state.expected - 3'd1;

  always_comb begin
    work = state;
    have = 1'b0;
    cp = '0;
    if (!state.ended) begin
      if (state.expected != '0 && is_cont) begin
        work.expected = exp_dec;
        work.partial = shifted;
        if (exp_dec == '0) begin
          have = 1'b1;
          cp = shifted;
          work.partial = '0;
        end
      end else begin
        work.expected = '0;
        work.partial = '0;
        if (data_byte == 8'h00) begin
          work.ended = 1'b1;
        end else if (!data_byte[7]) begin
          have = 1'b1;
          cp = {{(utf8d_pkg::CpWidth-8){1'b0}}, data_byte};
        end else if ((data_byte & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Tag) begin
          work.expected = 3'd1;
          work.partial = {{(utf8d_pkg::CpWidth-5){1'b0}}, data_byte[4:0]};
        end else if ((data_byte & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Tag) begin
          work.expected = 3'd2;
          work.partial = {{(utf8d_pkg::CpWidth-4){1'b0}}, data_byte[3:0]};
        end else if ((data_byte & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Tag) begin
          work.expected = 3'd3;
          work.partial = {{(utf8d_pkg::CpWidth-3){1'b0}}, data_byte[2:0]};
        end else if ((data_byte & utf8d_pkg::Lead5Mask) == utf8d_pkg::Lead5Tag) begin
          work.expected = 3'd4;
          work.partial = {{(utf8d_pkg::CpWidth-2){1'b0}}, data_byte[1:0]};
        end else if ((data_byte & utf8d_pkg::Lead6Mask) == utf8d_pkg::Lead6Tag) begin
          work.expected = 3'd5;
          work.partial = {{(utf8d_pkg::CpWidth-1){1'b0}}, data_byte[0]};
        end
      end
    end
    if (cp == '0) begin
      have = 1'b0;
    end
    result.emit = have || buffer_end;
    result.code_point = cp;
    result.has_code_point = have;
    result.done_res = buffer_end;
    if (buffer_end) begin
      state_next = '0;
    end else begin
      state_next = work;
    end
  end

endmodule

/* rtl/utf8d_out_reg.sv */
module utf8d_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  utf8d_pkg::dec_result_t        result,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [utf8d_pkg::CpWidth-1:0] code_point,
  output logic                          has_code_point,
  output logic                          done_res
);

  logic valid;
  logic valid_next;

  assign free = !valid || !out_stall;
  assign valid_next = load || (valid && out_stall);
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point <= result.code_point;
      has_code_point <= result.has_code_point;
      done_res <= result.done_res;
    end
  end

endmodule

/* rtl/utf8_stream_decoder_top.sv */
// UTF-8 byte stream decoder: one byte enters per transaction, and buffer_end marks the
// buffer's last byte. Sequences of 1 to 6 bytes (including the extended 5 and 6 byte
// forms, overlong forms and surrogates) decode to code points of up to 31 bits. A result
// transaction is sent for each completed nonzero character and exactly once for the last
// byte, where done_res is set; after that byte the decoder returns to its reset state.
// A zero byte ends the string and later bytes up to the last one give nothing. The block
// takes one byte per clock while in_stall is low; a byte passes through an input register
// and then a result register. When a waiting result is stalled and the input register
// holds a byte that yields a result, the input stalls as well. The decode state is
// updated by one shallow step of logic as each byte leaves the input register.
module utf8_stream_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          buffer_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [utf8d_pkg::CpWidth-1:0] code_point,
  output logic                          has_code_point,
  output logic                          done_res
);

  logic                   s1_valid;
  logic                   s1_valid_next;
  logic [7:0]             s1_byte;
  logic                   s1_end;
  logic                   accept;
  logic                   retire;
  logic                   out_free;
  utf8d_pkg::dec_state_t  state;
  utf8d_pkg::dec_state_t  state_next;
  utf8d_pkg::dec_result_t result;

  assign retire = s1_valid && (!result.emit || out_free);
  assign in_stall = s1_valid && !retire;
  assign accept = in_valid && !in_stall;
  assign s1_valid_next = accept || (s1_valid && !retire);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      state <= '0;
    end else begin
      s1_valid <= s1_valid_next;
      if (retire) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= data_byte;
      s1_end <= buffer_end;
    end
  end

  utf8d_decode u_decode (
    .state      (state),
    .data_byte  (s1_byte),
    .buffer_end (s1_end),
    .state_next (state_next),
    .result     (result)
  );

  utf8d_out_reg u_out_reg (
    .clk            (clk),
    .rst            (rst),
    .load           (retire && result.emit),
    .result         (result),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_point     (code_point),
    .has_code_point (has_code_point),
    .done_res       (done_res)
  );

  a_expected_range: assert property (@(posedge clk) disable iff (rst)
    state.expected <= utf8d_pkg::MaxExpected)
    else $error("continuation count out of range");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    retire && s1_end |=> state == '0)
    else $error("state not cleared after last byte");

  a_empty_is_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_code_point |-> done_res)
    else $error("result without character or done mark");

  a_nonzero_cp: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_code_point |-> code_point != '0)
    else $error("zero code point emitted");

endmodule

/* tb/utf8_char_checker.sv */
`timescale 1ns / 1ps

module utf8_char_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          buffer_end,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [utf8d_pkg::CpWidth-1:0] code_point,
  input  logic                          has_code_point,
  input  logic                          done_res,
  output int unsigned                   mismatch_count,
  output int unsigned                   pending_results
);

  typedef struct packed {
    logic [utf8d_pkg::CpWidth-1:0] cp;
    logic                          has_cp;
    logic                          done;
  } char_result_t;

  char_result_t expected_chars[$];

  logic [utf8d_pkg::ExpWidth-1:0] conts_left;
  logic [utf8d_pkg::CpWidth-1:0]  gathered_bits;
  logic                           text_ended;

  initial begin
    mismatch_count = 0;
    pending_results = 0;
    conts_left = '0;
    gathered_bits = '0;
    text_ended = 1'b0;
  end

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [utf8d_pkg::CpWidth-1:0] cp;
    logic                          have;
    logic                          as_lead;
    char_result_t                  res;
    cp = '0;
    have = 1'b0;
    as_lead = 1'b0;
    if (!text_ended) begin
      if (conts_left != '0) begin
        if ((b & utf8d_pkg::ContMask) == utf8d_pkg::ContTag) begin
          gathered_bits = {gathered_bits[utf8d_pkg::CpWidth-7:0], b[5:0]};
          conts_left = conts_left - 3'd1;
          if (conts_left == '0) begin
            cp = gathered_bits;
            have = 1'b1;
            gathered_bits = '0;
          end
        end else begin
          conts_left = '0;
          gathered_bits = '0;
          as_lead = 1'b1;
        end
      end else begin
        as_lead = 1'b1;
      end
      if (as_lead) begin
        if (b == 8'h00) begin
          text_ended = 1'b1;
        end else if (!b[7]) begin
          cp = {{(utf8d_pkg::CpWidth-7){1'b0}}, b[6:0]};
          have = 1'b1;
        end else if ((b & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Tag) begin
          conts_left = 3'd1;
          gathered_bits = {{(utf8d_pkg::CpWidth-5){1'b0}}, b[4:0]};
        end else if ((b & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Tag) begin
          conts_left = 3'd2;
          gathered_bits = {{(utf8d_pkg::CpWidth-4){1'b0}}, b[3:0]};
        end else if ((b & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Tag) begin
          conts_left = 3'd3;
          gathered_bits = {{(utf8d_pkg::CpWidth-3){1'b0}}, b[2:0]};
        end else if ((b & utf8d_pkg::Lead5Mask) == utf8d_pkg::Lead5Tag) begin
          conts_left = 3'd4;
          gathered_bits = {{(utf8d_pkg::CpWidth-2){1'b0}}, b[1:0]};
        end else if ((b & utf8d_pkg::Lead6Mask) == utf8d_pkg::Lead6Tag) begin
          conts_left = utf8d_pkg::MaxExpected;
          gathered_bits = {{(utf8d_pkg::CpWidth-1){1'b0}}, b[0]};
        end
      end
    end
    if (cp == '0) have = 1'b0;
    if (!have) cp = '0;
    res.cp = cp;
    res.has_cp = have;
    res.done = last;
    if (last) begin
      expected_chars.push_back(res);
      conts_left = '0;
      gathered_bits = '0;
      text_ended = 1'b0;
    end else if (have) begin
      expected_chars.push_back(res);
    end
  endtask

  always @(posedge clk) begin : watch
    char_result_t oldest;
    if (rst) begin
      conts_left = '0;
      gathered_bits = '0;
      text_ended = 1'b0;
      expected_chars.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result transaction cp=%h has=%b done=%b",
                     $realtime, code_point, has_code_point, done_res);
        end else begin
          oldest = expected_chars.pop_front();
          if (code_point !== oldest.cp || has_code_point !== oldest.has_cp ||
              done_res !== oldest.done) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display("%0t: mismatch, expected cp=%h has=%b done=%b, got cp=%h has=%b done=%b",
                       $realtime, oldest.cp, oldest.has_cp, oldest.done,
                       code_point, has_code_point, done_res);
          end
        end
      end
      if (in_valid && !in_stall) decode_byte(data_byte, buffer_end);
    end
    pending_results = expected_chars.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    data_byte;
  logic                          buffer_end;
  logic                          out_valid;
  logic                          out_stall;
  logic [utf8d_pkg::CpWidth-1:0] code_point;
  logic                          has_code_point;
  logic                          done_res;

  int unsigned mismatch_count;
  int unsigned pending_results;

  int          send_idle_pct;
  int          stall_pct;
  int          hold_requests;
  int unsigned bytes_sent;

  utf8_stream_decoder_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .buffer_end(buffer_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .code_point(code_point),
    .has_code_point(has_code_point),
    .done_res(done_res)
  );

  utf8_char_checker u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .buffer_end(buffer_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .code_point(code_point),
    .has_code_point(has_code_point),
    .done_res(done_res),
    .mismatch_count(mismatch_count),
    .pending_results(pending_results)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    buffer_end <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_sequence(input int len, input int n_cont, input logic last);
    logic [7:0] lead;
    logic [7:0] cont;
    lead = 8'($urandom);
    case (len)
      1: lead = 8'($urandom_range(1, 127));
      2: lead[7:5] = 3'b110;
      3: lead[7:4] = 4'b1110;
      4: lead[7:3] = 5'b11110;
      5: lead[7:2] = 6'b111110;
      default: lead[7:1] = 7'b1111110;
    endcase
    send_byte(lead, last && n_cont == 0);
    for (int i = 1; i <= n_cont; i++) begin
      cont = 8'($urandom);
      cont[7:6] = 2'b10;
      send_byte(cont, last && i == n_cont);
    end
  endtask

  task automatic send_buffer();
    int n_chars;
    int r;
    int len;
    logic [7:0] b;
    n_chars = $urandom_range(0, 10);
    repeat (n_chars) begin
      r = $urandom_range(99);
      if (r < 72) begin
        len = $urandom_range(1, 6);
        send_sequence(len, len - 1, 1'b0);
      end else if (r < 80) begin
        b = 8'($urandom);
        send_byte(b, 1'b0);
      end else if (r < 88) begin
        len = $urandom_range(2, 6);
        send_sequence(len, $urandom_range(0, len - 2), 1'b0);
      end else if (r < 93) begin
        b = 8'($urandom);
        b[7:6] = 2'b10;
        send_byte(b, 1'b0);
      end else if (r < 96) begin
        send_byte(8'h00, 1'b0);
      end else begin
        send_byte(8'($urandom_range(8'hFE, 8'hFF)), 1'b0);
      end
    end
    r = $urandom_range(99);
    if (r < 50) begin
      len = $urandom_range(1, 6);
      send_sequence(len, len - 1, 1'b1);
    end else if (r < 75) begin
      b = 8'($urandom);
      send_byte(b, 1'b1);
    end else begin
      len = $urandom_range(2, 6);
      send_sequence(len, $urandom_range(0, len - 2), 1'b1);
    end
  endtask

  initial begin : stimulus
    logic [8:0]  directed_bytes[$];
    int unsigned target;
    int          drain_cycles;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    buffer_end = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    bytes_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Each entry holds the last-byte flag above the data byte.
    directed_bytes = '{9'h07F, 9'h0C0, 9'h080, 9'h0E2, 9'h082, 9'h0AC,
                       9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
                       9'h0FB, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
                       9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
                       9'h080, 9'h0FE, 9'h0E2, 9'h041, 9'h1C3,
                       9'h000, 9'h142};
    foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        3: begin send_idle_pct = 6;  stall_pct = 6;  end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
          hold_requests++;
        end
      endcase
      target = bytes_sent + 220;
      while (bytes_sent < target) send_buffer();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    drain_cycles = 0;
    while (pending_results != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/utf8d_pkg.sv
rtl/utf8d_decode.sv
rtl/utf8d_out_reg.sv
rtl/utf8_stream_decoder_top.sv
tb/utf8_char_checker.sv
tb/tb.sv
